// ===== hw/rtl/imo_pkg.sv =====
// Shared types, codes and sizes for the integer matrix operation block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package imo_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int WORD_W      = 32;
    localparam int DIM_REG_W   = 4;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_IDX_W   = 3;

    // Operation codes held in op_mode.
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_TRN = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 3'd4;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [DIM_REG_W-1:0] rows_a;
        logic [DIM_REG_W-1:0] cols_a;
        logic [DIM_REG_W-1:0] rows_b;
        logic [DIM_REG_W-1:0] cols_b;
    } t_cfg;

    // Tag that travels beside each read pair through the arithmetic unit.
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last_k;
        logic                 last_run;
        logic                 err;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
    } t_tag;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic alu_busy;
        logic out_free;
    } t_drain;

endpackage

`default_nettype wire

// ===== hw/rtl/imo_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on imo_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module imo_ram #(
    parameter int WIDTH = imo_pkg::WORD_W,
    parameter int DEPTH = imo_pkg::MAX_DIM_DEF * imo_pkg::MAX_DIM_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/imo_alu.sv =====
// Shared arithmetic unit: one registered add/subtract/multiply stage followed by
// an accumulator that sums the terms of one result. Depends on imo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imo_alu (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [imo_pkg::OP_W-1:0]  i_op,
    input  wire imo_pkg::t_word            i_a,
    input  wire imo_pkg::t_word            i_b,
    input  wire imo_pkg::t_tag             i_tag,
    output logic                           o_valid,
    output imo_pkg::t_word                 o_value,
    output imo_pkg::t_tag                  o_tag,
    output logic                           o_busy
);

    imo_pkg::t_word n_p;
    imo_pkg::t_word r_p;
    imo_pkg::t_word r_acc;
    imo_pkg::t_word sum;
    imo_pkg::t_tag  r_tag;

    always_comb begin
        unique case (i_op)
            imo_pkg::OP_ADD: n_p = i_a + i_b;
            imo_pkg::OP_SUB: n_p = i_a - i_b;
            imo_pkg::OP_MUL: n_p = i_a * i_b;
            default:         n_p = i_a;
        endcase
    end

    // The first term of a result starts the sum afresh.
    assign sum = (r_tag.first ? '0 : r_acc) + r_p;

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (r_tag.valid) begin
            r_acc <= sum;
        end
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_tag.valid && r_tag.last_k;
    assign o_value = r_tag.err ? '0 : sum;
    assign o_tag   = r_tag;
    assign o_busy  = r_tag.valid;

endmodule

`default_nettype wire

// ===== hw/rtl/imo_seq.sv =====
// Sequencer: counts loaded elements, steers writes into the two matrix memories,
// then walks rows, columns and dot-product terms to issue reads. Depends on imo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imo_seq #(
    parameter int MAX_DIM = imo_pkg::MAX_DIM_DEF,
    localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire imo_pkg::t_cfg    i_cfg,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire imo_pkg::t_drain  i_drain,
    output logic                  o_we_a,
    output logic                  o_we_b,
    output logic [AW-1:0]         o_waddr,
    output logic [AW-1:0]         o_raddr_a,
    output logic [AW-1:0]         o_raddr_b,
    output imo_pkg::t_tag         o_tag
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int IW = $clog2(MAX_DIM);
    localparam int CW = $clog2(2 * MAX_DIM * MAX_DIM + 1);
    localparam int PW = AW + DW;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WAIT  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;

    function automatic logic [DW-1:0] clamp_dim(input logic [imo_pkg::DIM_REG_W-1:0] d);
        if (d == '0) begin
            return DW'(1);
        end
        if (32'(d) > MAX_DIM) begin
            return DW'(MAX_DIM);
        end
        return DW'(d);
    endfunction

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_err, n_err;
    logic          r_done, n_done;
    imo_pkg::t_tag r_tag, n_tag;

    logic [DW-1:0] ra, ca, rb, cb, rr, rc, len;
    logic [CW-1:0] size_a, size_b, total, pos_b, cnt_next;
    logic          is_trn, is_mul, mismatch, accept, in_a, tags_empty;
    logic          k_last, i_last, j_last, last_run;
    logic [IW-1:0] a_row, a_col, b_row;

    assign ra = clamp_dim(i_cfg.rows_a);
    assign ca = clamp_dim(i_cfg.cols_a);
    assign rb = clamp_dim(i_cfg.rows_b);
    assign cb = clamp_dim(i_cfg.cols_b);

    assign is_trn = (i_cfg.op == imo_pkg::OP_TRN);
    assign is_mul = (i_cfg.op == imo_pkg::OP_MUL);

    assign mismatch = is_mul ? (ca != rb) : (!is_trn && ((ra != rb) || (ca != cb)));
    assign rr  = is_trn ? ca : ra;
    assign rc  = is_trn ? ra : (is_mul ? cb : ca);
    assign len = is_mul ? ca : DW'(1);

    // Load side: element positions run through A first, then B.
    assign size_a   = CW'(ra) * CW'(ca);
    assign size_b   = CW'(rb) * CW'(cb);
    assign total    = is_trn ? size_a : size_a + size_b;
    assign pos_b    = r_cnt - size_a;
    assign cnt_next = r_cnt + CW'(1);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign in_a     = (r_cnt < size_a);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_we_a     = accept && in_a;
    assign o_we_b     = accept && !in_a && !is_trn && (pos_b < size_b);
    assign o_waddr    = in_a ? r_cnt[AW-1:0] : pos_b[AW-1:0];

    // Read side: transpose reads A by column, multiply walks k along a row of A
    // and down a column of B, add and subtract read matching entries.
    assign a_row = is_trn ? r_j : r_i;
    assign a_col = is_trn ? r_i : (is_mul ? r_k : r_j);
    assign b_row = is_mul ? r_k : r_i;

    assign o_raddr_a = AW'(PW'(a_row) * PW'(ca) + PW'(a_col));
    assign o_raddr_b = AW'(PW'(b_row) * PW'(cb) + PW'(r_j));

    assign k_last   = r_err || (DW'(r_k) == len - DW'(1));
    assign i_last   = (DW'(r_i) == rr - DW'(1));
    assign j_last   = (DW'(r_j) == rc - DW'(1));
    assign last_run = r_err || (i_last && j_last);

    assign tags_empty = !r_tag.valid && !i_drain.alu_busy;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_err   = r_err;
        n_done  = r_done;
        n_tag   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (cnt_next >= total) begin
                        n_cnt   = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_err   = mismatch;
                        n_done  = 1'b0;
                        n_state = S_WAIT;
                    end else begin
                        n_cnt = cnt_next;
                    end
                end
            end
            S_WAIT: begin
                if (r_done) begin
                    if (tags_empty) begin
                        n_state = S_IDLE;
                    end
                end else if (tags_empty && i_drain.out_free) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_tag.valid    = 1'b1;
                n_tag.first    = (r_k == '0);
                n_tag.last_k   = k_last;
                n_tag.last_run = last_run;
                n_tag.err      = r_err;
                n_tag.row      = r_err ? '0 : imo_pkg::OUT_IDX_W'(r_i);
                n_tag.col      = r_err ? '0 : imo_pkg::OUT_IDX_W'(r_j);
                if (k_last) begin
                    n_k = '0;
                    if (j_last) begin
                        n_j = '0;
                        n_i = r_i + IW'(1);
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                    n_done  = last_run;
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_err   <= 1'b0;
            r_done  <= 1'b0;
            r_tag   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_err   <= n_err;
            r_done  <= n_done;
            r_tag   <= n_tag;
        end
    end

    // The tag is registered together with the memory read, so it lines up with
    // the read data at the arithmetic unit.
    assign o_tag = r_tag;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_matrix_ops.sv =====
// Loading takes elements back to back; s_axis_tready is high only while loading.
// After the last element, each result sums L terms, where L is cols_a for multiply
// and 1 otherwise; the sequencer issues the terms of one result only once the
// arithmetic unit has drained and the output register is free.
// Reset (synchronous, active low) sets op_mode to multiply, all dimensions to 1
// and the load count to zero; the matrix memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_ops #(
    parameter int MAX_DIM = imo_pkg::MAX_DIM_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [imo_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [imo_pkg::DIM_REG_W-1:0]   i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [31:0]                     s_axis_tdata,  // element_value
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [39:0]                          m_axis_tdata,  // result_value, result_row, result_col
    output logic                                 m_axis_tlast,  // last_of_run
    output logic [0:0]                           m_axis_tuser   // dims_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    imo_pkg::t_cfg   r_cfg;
    imo_pkg::t_drain drain;
    imo_pkg::t_tag   seq_tag;
    imo_pkg::t_tag   alu_tag;
    imo_pkg::t_word  rd_a, rd_b, alu_value;
    logic            we_a, we_b, alu_valid, alu_busy;
    logic [AW-1:0]   waddr, raddr_a, raddr_b;

    logic                              r_m_valid;
    imo_pkg::t_word                    r_m_value;
    logic [imo_pkg::OUT_IDX_W-1:0]     r_m_row, r_m_col;
    logic                              r_m_last, r_m_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.op     <= imo_pkg::OP_MUL;
            r_cfg.rows_a <= imo_pkg::DIM_REG_W'(1);
            r_cfg.cols_a <= imo_pkg::DIM_REG_W'(1);
            r_cfg.rows_b <= imo_pkg::DIM_REG_W'(1);
            r_cfg.cols_b <= imo_pkg::DIM_REG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                imo_pkg::REG_OP_MODE: r_cfg.op     <= i_cfg_wdata[imo_pkg::OP_W-1:0];
                imo_pkg::REG_ROWS_A:  r_cfg.rows_a <= i_cfg_wdata;
                imo_pkg::REG_COLS_A:  r_cfg.cols_a <= i_cfg_wdata;
                imo_pkg::REG_ROWS_B:  r_cfg.rows_b <= i_cfg_wdata;
                imo_pkg::REG_COLS_B:  r_cfg.cols_b <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign drain.alu_busy = alu_busy;
    assign drain.out_free = !r_m_valid || m_axis_tready;

    imo_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_drain    (drain),
        .o_we_a     (we_a),
        .o_we_b     (we_b),
        .o_waddr    (waddr),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b),
        .o_tag      (seq_tag)
    );

    imo_ram #(
        .WIDTH (imo_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    imo_ram #(
        .WIDTH (imo_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    imo_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (r_cfg.op),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .i_tag   (seq_tag),
        .o_valid (alu_valid),
        .o_value (alu_value),
        .o_tag   (alu_tag),
        .o_busy  (alu_busy)
    );

    // Output register: the sequencer only issues a result once this is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (alu_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (alu_valid) begin
            r_m_value <= alu_value;
            r_m_row   <= alu_tag.row;
            r_m_col   <= alu_tag.col;
            r_m_last  <= alu_tag.last_run;
            r_m_err   <= alu_tag.err;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = {2'b00, r_m_col, r_m_row, r_m_value};
    assign m_axis_tlast    = r_m_last;
    assign m_axis_tuser[0] = r_m_err;

    // A finished result never lands on one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_valid |-> !(r_m_valid && !m_axis_tready))
        else $error("result overwrote a pending output transaction");

    // While reads are in flight the block takes no new element.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_tag.valid |-> !s_axis_tready)
        else $error("input accepted while results are being computed");

    // An error result is the only result of its run and carries a zero value.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("dimension error result malformed");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_valid |=> m_axis_tvalid)
        else $error("finished result did not reach the output");

endmodule

`default_nettype wire

// ===== verif/tb_integer_matrix_ops.sv =====
// Self-checking testbench for integer_matrix_ops: loads matrix pairs over the input stream
// and checks every result transaction against a cycle-free model of the matrix operations.
// Depends on imo_pkg and the integer_matrix_ops RTL.
`timescale 1ns / 1ps

module tb_integer_matrix_ops;
    import imo_pkg::*;

    localparam int DIM_MAX      = MAX_DIM_DEF;
    localparam int CELL_CNT     = DIM_MAX * DIM_MAX;
    localparam int RAND_ITEMS   = 240;
    localparam int SETTLE_CYCLS = 16;
    localparam int DIR_ROWS     = 8;
    localparam int REPORT_MAX   = 10;
    // An index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0]    value;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
        logic                 last;
        logic                 err;
    } t_mat_result;

    typedef struct packed {
        logic                 use_cfg;
        logic [DIM_REG_W-1:0] op;
        logic [DIM_REG_W-1:0] ra;
        logic [DIM_REG_W-1:0] ca;
        logic [DIM_REG_W-1:0] rb;
        logic [DIM_REG_W-1:0] cb;
        logic [WORD_W-1:0]    e0;
        logic [WORD_W-1:0]    e1;
        logic [WORD_W-1:0]    e2;
        logic                 typed;
        logic [WORD_W-1:0]    exp_value;
        logic                 exp_err;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_REG_W-1:0] cfg_data;
    logic                 s_valid;
    logic [31:0]          s_data;
    logic                 m_ready;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [39:0]          m_axis_tdata;  // result_value, result_row, result_col
    logic                 m_axis_tlast;  // last_of_run
    logic [0:0]           m_axis_tuser;  // dims_error

    integer_matrix_ops i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_idx),
        .i_cfg_wdata   (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Model copy of the registers and the matrix stores.
    logic [OP_W-1:0]      mdl_op;
    logic [DIM_REG_W-1:0] mdl_ra, mdl_ca, mdl_rb, mdl_cb;
    t_word                mat_a [CELL_CNT];
    t_word                mat_b [CELL_CNT];
    int unsigned          load_cnt;

    t_mat_result pending_results [$];
    int          mismatch_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;
    t_dir_row    dir_tab [DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("integer_matrix_ops test failed");
        $finish;
    end

    function automatic int unsigned eff_dim(input logic [DIM_REG_W-1:0] d);
        if (d < 1) return 1;
        if (d > DIM_MAX) return DIM_MAX;
        return int'(d);
    endfunction

    function automatic int unsigned run_length();
        int unsigned sa, sb;
        sa = eff_dim(mdl_ra) * eff_dim(mdl_ca);
        sb = eff_dim(mdl_rb) * eff_dim(mdl_cb);
        return (mdl_op == OP_TRN) ? sa : sa + sb;
    endfunction

    // Stores one accepted element; when it completes a tracked run, queues its results.
    task automatic absorb_element(input t_word v, input bit track);
        int unsigned ra, ca, rb, cb, sa, sb, pos, rr, rc;
        t_word       acc;
        t_mat_result res;
        ra  = eff_dim(mdl_ra);
        ca  = eff_dim(mdl_ca);
        rb  = eff_dim(mdl_rb);
        cb  = eff_dim(mdl_cb);
        sa  = ra * ca;
        sb  = rb * cb;
        pos = load_cnt;
        if (pos < sa)
            mat_a[pos] = v;
        else if (mdl_op != OP_TRN && pos - sa < sb)
            mat_b[pos - sa] = v;
        load_cnt = pos + 1;
        if (load_cnt < run_length())
            return;
        load_cnt = 0;
        if (!track)
            return;
        res.value = '0;
        res.row   = '0;
        res.col   = '0;
        res.last  = 1'b1;
        res.err   = 1'b1;
        if ((mdl_op == OP_MUL && ca != rb) ||
            ((mdl_op == OP_ADD || mdl_op == OP_SUB) && (ra != rb || ca != cb))) begin
            pending_results.push_back(res);
            return;
        end
        rr = (mdl_op == OP_TRN) ? ca : ra;
        rc = (mdl_op == OP_TRN) ? ra : ((mdl_op == OP_MUL) ? cb : ca);
        for (int unsigned i = 0; i < rr; i++) begin
            for (int unsigned j = 0; j < rc; j++) begin
                case (mdl_op)
                    OP_TRN: acc = mat_a[j * ca + i];
                    OP_ADD: acc = mat_a[i * ca + j] + mat_b[i * ca + j];
                    OP_SUB: acc = mat_a[i * ca + j] - mat_b[i * ca + j];
                    default: begin
                        acc = '0;
                        for (int unsigned k = 0; k < ca; k++)
                            acc = acc + mat_a[i * ca + k] * mat_b[k * cb + j];
                    end
                endcase
                res.value = acc;
                res.row   = i[OUT_IDX_W-1:0];
                res.col   = j[OUT_IDX_W-1:0];
                res.last  = (i + 1 == rr) && (j + 1 == rc);
                res.err   = 1'b0;
                pending_results.push_back(res);
            end
        end
    endtask

    function automatic t_word rand_element();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom();
        if (pick < 80)
            return t_word'($urandom_range(0, 16)) - 32'd8;
        case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0001;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // Mostly small sizes; zero and values at or above the maximum exercise the clamping.
    function automatic logic [DIM_REG_W-1:0] rand_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78) return DIM_REG_W'($urandom_range(1, 3));
        if (pick < 90) return DIM_REG_W'($urandom_range(4, 6));
        if (pick < 94) return '0;
        return DIM_REG_W'($urandom_range(DIM_MAX, 15));
    endfunction

    // Called at a falling edge; returns at the falling edge after the register write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_REG_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        case (idx)
            REG_OP_MODE: mdl_op = d[OP_W-1:0];
            REG_ROWS_A:  mdl_ra = d;
            REG_COLS_A:  mdl_ca = d;
            REG_ROWS_B:  mdl_rb = d;
            REG_COLS_B:  mdl_cb = d;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [DIM_REG_W-1:0] op, input logic [DIM_REG_W-1:0] ra,
                            input logic [DIM_REG_W-1:0] ca, input logic [DIM_REG_W-1:0] rb,
                            input logic [DIM_REG_W-1:0] cb, input bit stray);
        write_reg(REG_OP_MODE, op);
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
        if (stray)
            write_reg(REG_NONE, DIM_REG_W'($urandom_range(0, 15)));
        cfg_we <= 1'b0;
    endtask

    // Called at a falling edge with tvalid either low or still high from the last element.
    task automatic send_element(input t_word v, input bit track);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_element(v, track);
        @(negedge i_clk);
    endtask

    // Lets the whole result matrix come out and the block settle before new settings.
    task automatic end_run();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLS) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge i_clk) begin : result_check
        t_mat_result got, want;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            got.value = m_axis_tdata[31:0];
            got.row   = m_axis_tdata[34:32];
            got.col   = m_axis_tdata[37:35];
            got.last  = m_axis_tlast;
            got.err   = m_axis_tuser[0];
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result value %h row %0d col %0d last %b err %b",
                             $realtime, got.value, got.row, got.col, got.last, got.err);
            end else begin
                want = pending_results.pop_front();
                if (got != want || m_axis_tdata[39:38] != 2'b00) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display({"%0t: expected value %h row %0d col %0d last %b err %b,",
                                  " got value %h row %0d col %0d last %b err %b pad %b"},
                                 $realtime, want.value, want.row, want.col, want.last,
                                 want.err, got.value, got.row, got.col, got.last, got.err,
                                 m_axis_tdata[39:38]);
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row             row;
        t_word                v;
        t_mat_result          typed_res;
        int unsigned          n;
        int                   rand_items;
        logic [OP_W-1:0]      op;
        logic [1:0]           op_hi;
        logic [DIM_REG_W-1:0] ra, ca, rb, cb;

        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        mismatch_cnt  = 0;
        send_idle_pct = 24;
        recv_idle_pct = 69;
        mdl_op        = OP_MUL;
        mdl_ra        = 4'd1;
        mdl_ca        = 4'd1;
        mdl_rb        = 4'd1;
        mdl_cb        = 4'd1;
        load_cnt      = 0;
        rand_items    = 0;

        // use_cfg, op, rows_a, cols_a, rows_b, cols_b, three leading elements,
        // typed, expected value, expected error.
        dir_tab[0] = '{1'b0, {2'b00, OP_MUL}, 4'd1, 4'd1, 4'd1, 4'd1,
                       32'd7, 32'hffff_fffd, 32'd0, 1'b1, 32'hffff_ffeb, 1'b0};
        dir_tab[1] = '{1'b1, {2'b00, OP_ADD}, 4'd1, 4'd1, 4'd1, 4'd1,
                       32'h7fff_ffff, 32'd1, 32'd0, 1'b1, 32'h8000_0000, 1'b0};
        dir_tab[2] = '{1'b1, {2'b00, OP_SUB}, 4'd1, 4'd1, 4'd1, 4'd1,
                       32'h8000_0000, 32'd1, 32'd0, 1'b1, 32'h7fff_ffff, 1'b0};
        dir_tab[3] = '{1'b1, {2'b00, OP_MUL}, 4'd1, 4'd1, 4'd1, 4'd1,
                       32'h8000_0000, 32'hffff_ffff, 32'd0, 1'b1, 32'h8000_0000, 1'b0};
        // Inner dimensions differ for the product.
        dir_tab[4] = '{1'b1, {2'b00, OP_MUL}, 4'd1, 4'd2, 4'd1, 4'd1,
                       32'd5, 32'd6, 32'd7, 1'b1, 32'd0, 1'b1};
        // Shapes differ for the difference.
        dir_tab[5] = '{1'b1, {2'b00, OP_SUB}, 4'd1, 4'd1, 4'd2, 4'd1,
                       32'd1, 32'd2, 32'd3, 1'b1, 32'd0, 1'b1};
        // Transpose of a clamped 1x8 matrix; the mismatched B shape must not matter.
        dir_tab[6] = '{1'b1, {2'b11, OP_TRN}, 4'd0, 4'd9, 4'd3, 4'd5,
                       32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 32'd0, 1'b0};
        // All dimensions zero clamp to 1x1; the upper data bits of the mode are dropped.
        dir_tab[7] = '{1'b1, {2'b01, OP_MUL}, 4'd0, 4'd0, 4'd0, 4'd0,
                       32'hffff_ffff, 32'hffff_ffff, 32'd0, 1'b1, 32'd1, 1'b0};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_tab[r];
            if (row.use_cfg)
                set_regs(row.op, row.ra, row.ca, row.rb, row.cb, r == 1);
            n = run_length();
            if (row.typed) begin
                typed_res.value = row.exp_value;
                typed_res.row   = '0;
                typed_res.col   = '0;
                typed_res.last  = 1'b1;
                typed_res.err   = row.exp_err;
                pending_results.push_back(typed_res);
            end
            for (int unsigned k = 0; k < n; k++) begin
                case (k)
                    0: v = row.e0;
                    1: v = row.e1;
                    2: v = row.e2;
                    default: v = rand_element();
                endcase
                send_element(v, !row.typed);
            end
            end_run();
        end

        while (rand_items < RAND_ITEMS) begin
            if (rand_items < RAND_ITEMS / 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 69;
            end else if (rand_items < 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 69;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            op    = OP_W'($urandom_range(0, 3));
            op_hi = 2'($urandom_range(0, 3));
            ra    = rand_dim();
            ca    = rand_dim();
            rb    = rand_dim();
            cb    = rand_dim();
            // Most runs have shapes that suit the operation.
            if ($urandom_range(0, 99) < 85) begin
                if (op == OP_ADD || op == OP_SUB) begin
                    rb = ra;
                    cb = ca;
                end else if (op == OP_MUL) begin
                    rb = ca;
                end
            end
            set_regs({op_hi, op}, ra, ca, rb, cb, $urandom_range(0, 9) == 0);
            n = run_length();
            rand_items += n;
            for (int unsigned k = 0; k < n; k++)
                send_element(rand_element(), 1'b1);
            end_run();
        end

        if (pending_results.size() != 0) begin
            mismatch_cnt++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (mismatch_cnt == 0)
            $display("integer_matrix_ops test passed");
        else
            $display("integer_matrix_ops test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/imo_pkg.sv
hw/rtl/imo_ram.sv
hw/rtl/imo_alu.sv
hw/rtl/imo_seq.sv
hw/rtl/integer_matrix_ops.sv
verif/tb_integer_matrix_ops.sv
